>>> hw/rtl/rba_pkg.sv
// shared types and constants for the ring buffer aligned allocator
// no dependencies; imported by rba_pad_serial, the top level and the testbench
package rba_pkg;

  // alignment fields are 16 bits wide
  localparam int unsigned AlignW = 16;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CAPACITY  = 2'd0;
  localparam cfg_idx_t CFG_MIN_ALIGN = 2'd1;

  // sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_HEAD,
    ST_START,
    ST_SUM,
    ST_PLACE,
    ST_DIV_END,
    ST_ROUND,
    ST_FINISH,
    ST_DONE
  } rba_state_e;

  // where the region lands
  typedef enum logic [1:0] {
    PL_WRAP,
    PL_EXACT,
    PL_ORDINARY
  } rba_place_e;

  // status of the serial padding unit
  typedef struct packed {
    logic busy;
    logic done;
  } rba_div_status_t;

endpackage

>>> hw/rtl/rba_pad_serial.sv
// bit-serial remainder unit: returns the padding that rounds a value up to a divisor
// depends on rba_pkg
module rba_pad_serial #(
  parameter int unsigned DW = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 dividend_i,
  input  logic [rba_pkg::AlignW-1:0]    divisor_i,
  output rba_pkg::rba_div_status_t      status_o,
  output logic [rba_pkg::AlignW-1:0]    pad_o
);
  import rba_pkg::*;

  localparam int unsigned CntW = $clog2(DW);

  logic [DW-1:0]     num_q;
  logic [AlignW-1:0] rem_q;
  logic [AlignW-1:0] dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [AlignW:0]   trial;
  logic [AlignW:0]   diff;
  logic [AlignW-1:0] rem_d;

  // one restoring step: bring in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[AlignW-1:0];
    end else begin
      rem_d = trial[AlignW-1:0];
    end
  end

  // control: step counter and busy/done flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath: dividend shifts out msb first, remainder accumulates
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= (divisor_i > AlignW'(1)) ? divisor_i : AlignW'(1);
    end else if (busy_q) begin
      num_q <= {num_q[DW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  // padding up to the next multiple
  assign pad_o         = (rem_q == '0) ? '0 : (dvs_q - rem_q);
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> hw/rtl/ring_buffer_aligned_allocator.sv
// channel  | valid       | stall       | payload
// request  | in_valid_i  | in_stall_o  | alloc_size_i, align_i, tail_i
// grant    | out_valid_o | out_stall_i | ok_o, offset_o
// config   | cfg_we_i    | (none)      | cfg_index_i, cfg_data_i
//
// an item runs from accept to the next accept through check, a first pass of the bit-serial
// remainder unit, add, compare, a second pass and the update and output steps; a new item is
// taken only once the grant is loaded into the output register
// an oversize item goes from check straight to output; an exact fit skips the second pass
// reset clears head, the registers (capacity all ones, min alignment zero) and control
// the next item is taken while a grant waits on a stalled output register
// top level of the ring buffer aligned allocator; depends on rba_pkg and rba_pad_serial
module ring_buffer_aligned_allocator #(
  parameter int unsigned OFFSET_BITS = 24,
  localparam int unsigned CfgW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  rba_pkg::cfg_idx_t            cfg_index_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  // request
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [OFFSET_BITS-1:0]       alloc_size_i,
  input  logic [rba_pkg::AlignW-1:0]   align_i,
  input  logic [OFFSET_BITS-1:0]       tail_i,
  // grant
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [OFFSET_BITS-1:0]       offset_o
);
  import rba_pkg::*;

  localparam int unsigned W  = OFFSET_BITS;
  localparam int unsigned XW = CfgW + 2;

  rba_state_e        state_q, state_d;
  rba_place_e        place_q;
  logic [W-1:0]      cap_q;
  logic [AlignW-1:0] minal_q;
  logic [W-1:0]      head_q;
  logic [W-1:0]      size_q;
  logic [AlignW-1:0] align_q;
  logic [W-1:0]      tail_q;
  logic [XW-1:0]     start_q;
  logic [XW-1:0]     end_q;
  logic              res_ok_q;
  logic [W-1:0]      res_off_q;
  logic              out_valid_q;
  logic              ok_q;
  logic [W-1:0]      offset_q;

  logic              accept;
  logic              div_start;
  logic [W-1:0]      div_num;
  logic [AlignW-1:0] div_dvs;
  logic              out_load;
  rba_div_status_t   div_status;
  logic [AlignW-1:0] pad;

  logic              oversize;
  logic              is_wrap;
  logic              is_exact;
  logic [XW-1:0]     clamp_end;
  logic [XW-1:0]     fin_end;
  logic              fin_ok;

  assign accept   = in_valid_i && !in_stall_o;
  assign oversize = size_q > cap_q;
  assign is_wrap  = end_q > XW'(cap_q);
  assign is_exact = end_q == XW'(cap_q);

  // padding unit shared by the start round-up and the end round-up
  rba_pad_serial #(
    .DW (W)
  ) u_pad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .status_o   (div_status),
    .pad_o      (pad)
  );

  // final decision for wrap and ordinary placement
  always_comb begin
    clamp_end = (end_q > XW'(cap_q)) ? XW'(cap_q) : end_q;
    if (place_q == PL_WRAP) begin
      fin_end = end_q;
      fin_ok  = !(end_q >= XW'(tail_q));
    end else begin
      fin_end = clamp_end;
      fin_ok  = (head_q >= tail_q) == (clamp_end >= XW'(tail_q));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = ST_CHECK;
      ST_CHECK:    state_d = oversize ? ST_DONE : ST_DIV_HEAD;
      ST_DIV_HEAD: if (div_status.done) state_d = ST_START;
      ST_START:    state_d = ST_SUM;
      ST_SUM:      state_d = ST_PLACE;
      ST_PLACE:    state_d = (!is_wrap && is_exact) ? ST_DONE : ST_DIV_END;
      ST_DIV_END:  if (div_status.done) state_d = ST_ROUND;
      ST_ROUND:    state_d = ST_FINISH;
      ST_FINISH:   state_d = ST_DONE;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = 1'b0;
    div_num    = head_q;
    div_dvs    = align_q;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CHECK: begin
        div_start = !oversize;
      end
      ST_PLACE: begin
        div_start = is_wrap || !is_exact;
        div_num   = is_wrap ? size_q : end_q[W-1:0];
        div_dvs   = minal_q;
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // state, head, registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cap_q       <= '1;
      minal_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CAPACITY) cap_q <= cfg_data_i[W-1:0];
        if (cfg_index_i == CFG_MIN_ALIGN) minal_q <= cfg_data_i[AlignW-1:0];
      end
      if (state_q == ST_PLACE && !is_wrap && is_exact && !(tail_q > head_q)) begin
        head_q <= cap_q;
      end
      if (state_q == ST_FINISH && fin_ok) begin
        head_q <= fin_end[W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q  <= alloc_size_i;
      align_q <= align_i;
      tail_q  <= tail_i;
    end
    unique case (state_q)
      ST_CHECK: begin
        res_ok_q  <= 1'b0;
        res_off_q <= '0;
      end
      ST_START: begin
        start_q <= XW'(head_q) + XW'(pad);
      end
      ST_SUM: begin
        end_q <= start_q + XW'(size_q);
      end
      ST_PLACE: begin
        if (is_wrap) begin
          place_q <= PL_WRAP;
          start_q <= '0;
          end_q   <= XW'(size_q);
        end else if (is_exact) begin
          place_q   <= PL_EXACT;
          res_ok_q  <= !(tail_q > head_q);
          res_off_q <= (tail_q > head_q) ? '0 : start_q[W-1:0];
        end else begin
          place_q <= PL_ORDINARY;
        end
      end
      ST_ROUND: begin
        end_q <= end_q + XW'(pad);
      end
      ST_FINISH: begin
        res_ok_q  <= fin_ok;
        res_off_q <= fin_ok ? start_q[W-1:0] : '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      ok_q     <= res_ok_q;
      offset_q <= res_off_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign offset_o    = offset_q;

endmodule

>>> hw/rtl/rba_checker.sv
// port-level checks for the ring buffer aligned allocator, bound to the top level
// depends on ring_buffer_aligned_allocator
module rba_checker #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         ok_o,
  input logic [OFFSET_BITS-1:0]       offset_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // at most one item in work plus one waiting in the output register
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  // no result without an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a request");

  // an accepted item stalls the request side after the accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request side open right after accept");

  // a stalled grant holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) && $stable(offset_o))
    else $error("stalled grant changed");

endmodule

bind ring_buffer_aligned_allocator rba_checker #(.OFFSET_BITS(OFFSET_BITS)) u_rba_checker (.*);

>>> test/tb.sv
// testbench for ring_buffer_aligned_allocator: directed and random requests over several
// capacity and padding settings, each grant checked against an in-bench region planner
// depends on rba_pkg and the allocator rtl
`timescale 1ns / 100ps

module tb;
  import rba_pkg::*;

  localparam int unsigned OfsW = 24;
  localparam int unsigned CfgW = (OfsW > 16) ? OfsW : 16;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned SettleCycles = 2 * OfsW + 16;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned QuietLimit = 4000;

  // indexes past the register list, writes there are ignored
  localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

  typedef logic [OfsW-1:0] ofs_t;
  typedef logic [AlignW-1:0] aln_t;
  typedef logic [63:0] wide_t;

  typedef struct packed {
    ofs_t size;
    aln_t align;
    ofs_t tail;
  } alloc_req_t;

  typedef struct packed {
    logic ok;
    ofs_t offset;
  } grant_t;

  typedef struct packed {
    ofs_t capacity;
    aln_t min_align;
  } ring_cfg_t;

  localparam ring_cfg_t CfgAtReset = '{capacity: '1, min_align: '0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_t cfg_index_i = CFG_CAPACITY;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ofs_t alloc_size_i = '0;
  aln_t align_i = '0;
  ofs_t tail_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic ok_o;
  ofs_t offset_o;

  ring_buffer_aligned_allocator #(
    .OFFSET_BITS(OfsW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .alloc_size_i(alloc_size_i),
    .align_i    (align_i),
    .tail_i     (tail_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .offset_o   (offset_o)
  );

  wire req_fire = in_valid_i && !in_stall_o;
  wire grant_fire = out_valid_o && !out_stall_i;

  // pending requests and the grants they should produce
  alloc_req_t req_q[$];
  grant_t grant_q[$];

  // checker copy of registers and head, followed from the pins
  ring_cfg_t model_cfg = CfgAtReset;
  ofs_t model_head = '0;
  // generator copy, used to aim tails near the live head
  ring_cfg_t gen_cfg = CfgAtReset;
  ofs_t gen_head = '0;

  logic req_fire_q = 1'b0;
  logic idle_en = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned n_req = 0;
  int unsigned n_granted = 0;
  int unsigned n_refused = 0;

  ofs_t phase_cap[NumPhases] = '{24'hFF_FFFF, 24'd1000, 24'd4096, 24'd300,
                                 24'd65536, 24'hFF_FFFF, 24'd1000, 24'd50};
  aln_t phase_ma[NumPhases] = '{16'd0, 16'd64, 16'd1, 16'd7, 16'd16, 16'hFFFF, 16'd0, 16'd0};

  // round v up to a multiple of a (a >= 1)
  function automatic wide_t pad_to(input wide_t v, input wide_t a);
    return ((v + a - 1) / a) * a;
  endfunction

  // where the next region goes and where the head ends up
  function automatic void plan_region(input ring_cfg_t c, input ofs_t head_now,
                                      input alloc_req_t r, output grant_t g,
                                      output ofs_t head_next);
    wide_t sz, al, tl, hd, cap, ma, st, en;
    logic fits;
    sz = r.size;
    al = r.align;
    tl = r.tail;
    hd = head_now;
    cap = c.capacity;
    ma = c.min_align;
    st = '0;
    en = hd;
    fits = 1'b1;
    g = '0;
    head_next = head_now;
    if (sz > cap) begin
      fits = 1'b0;
    end else begin
      st = (al > 1) ? pad_to(hd, al) : hd;
      en = st + sz;
      if (en > cap) begin
        // no room above the head, restart at offset zero, no clamp here
        st = '0;
        en = sz;
        if (ma > 0) en = pad_to(en, ma);
        fits = (en < tl);
      end else if (en == cap) begin
        // region runs exactly to the top
        fits = !(tl > hd);
      end else begin
        // padded end, clamped to capacity, must not step over the tail
        if (ma > 1) begin
          en = pad_to(en, ma);
          if (en > cap) en = cap;
        end
        fits = ((hd >= tl) == (en >= tl));
      end
    end
    if (fits) begin
      g.ok = 1'b1;
      g.offset = st[OfsW-1:0];
      head_next = en[OfsW-1:0];
    end
  endfunction

  // random request: mostly sized against capacity with tails near the head, some raw noise
  function automatic alloc_req_t pick_req(input ofs_t cap, input ofs_t hd);
    alloc_req_t r;
    longint unsigned span, t;
    span = longint'(cap) + 1;
    if ($urandom_range(99) < 8) begin
      r.size = ofs_t'($urandom);
      r.align = aln_t'($urandom);
      r.tail = ofs_t'($urandom);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: r.size = ofs_t'($urandom_range(0, cap / 8));
        5, 6: r.size = ofs_t'($urandom_range(0, cap));
        7: r.size = ofs_t'(cap - $urandom_range(0, (cap < 3) ? cap : 3));
        default: r.size = ofs_t'(cap + $urandom_range(1, 3));
      endcase
      case ($urandom_range(5))
        0: r.align = '0;
        1: r.align = aln_t'(1);
        2: r.align = aln_t'(1) << $urandom_range(1, 10);
        3: r.align = aln_t'($urandom_range(2, 100));
        4: r.align = '1;
        default: r.align = aln_t'($urandom);
      endcase
      case ($urandom_range(7))
        0, 1, 2: t = (longint'(hd) + $urandom_range(0, cap)) % span;
        3: t = (hd > 4) ? hd - $urandom_range(0, 4) : hd;
        4: t = $urandom_range(0, cap);
        5: t = 0;
        6: t = cap;
        default: t = hd;
      endcase
      r.tail = ofs_t'(t);
    end
    return r;
  endfunction

  task automatic queue_req(input ofs_t sz, input aln_t al, input ofs_t tl);
    alloc_req_t r;
    grant_t g;
    ofs_t nh;
    r = '{size: sz, align: al, tail: tl};
    plan_region(gen_cfg, gen_head, r, g, nh);
    gen_head = nh;
    req_q.push_back(r);
  endtask

  // write both registers, junk in the unused upper bits of min alignment
  task automatic set_config(input ofs_t cap, input aln_t ma);
    logic [CfgW-1:0] junk;
    junk = CfgW'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CAPACITY;
    cfg_data_i <= CfgW'(cap);
    @(negedge clk_i);
    cfg_index_i <= CFG_MIN_ALIGN;
    cfg_data_i <= {junk[CfgW-1:AlignW], ma};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    gen_cfg = '{capacity: cap, min_align: ma};
  endtask

  // wait until every request is taken and granted, then let the block settle
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || grant_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    alloc_req_t nxt;
    if (!in_valid_i || req_fire_q) begin
      if (req_q.size() == 0 || (idle_en && $urandom_range(99) < 11)) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        in_valid_i <= 1'b1;
        alloc_size_i <= nxt.size;
        align_i <= nxt.align;
        tail_i <= nxt.tail;
      end
    end
  end

  // grant receiver, random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldOffCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 11);
    end
  end

  // monitor: follow register writes, predict each taken item, check each grant
  always @(posedge clk_i) begin
    alloc_req_t r;
    grant_t g;
    ofs_t nh;
    if (rst_ni) begin
      req_fire_q <= req_fire;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: model_cfg.capacity = cfg_data_i[OfsW-1:0];
          CFG_MIN_ALIGN: model_cfg.min_align = cfg_data_i[AlignW-1:0];
          default: ;
        endcase
      end
      if (req_fire) begin
        r = '{size: alloc_size_i, align: align_i, tail: tail_i};
        plan_region(model_cfg, model_head, r, g, nh);
        model_head = nh;
        grant_q.push_back(g);
        n_req++;
        if (g.ok) n_granted++;
        else n_refused++;
      end
      if (grant_fire) begin
        if (grant_q.size() == 0) begin
          $error("tb: grant with no request outstanding, ok %0d offset %0d", ok_o, offset_o);
          err_cnt++;
        end else begin
          g = grant_q.pop_front();
          if (ok_o !== g.ok) begin
            $error("tb: ok mismatch, expected %0d, got %0d", g.ok, ok_o);
            err_cnt++;
          end
          if (offset_o !== g.offset) begin
            $error("tb: offset mismatch, expected %0d, got %0d", g.offset, offset_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (!rst_ni || req_fire || grant_fire || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    alloc_req_t r;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes past the register list must change nothing
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SPARE_LO;
    cfg_data_i <= CfgW'($urandom);
    @(negedge clk_i);
    cfg_index_i <= CFG_SPARE_HI;
    cfg_data_i <= '1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    // reset settings: zero size, full ring exact fit, wrap from the top, crossing the tail
    queue_req('0, 16'd0, '0);
    queue_req('1, 16'd1, '0);
    queue_req(24'd5, 16'hFFFF, '1);
    queue_req(24'd16, 16'd4, 24'd3);
    queue_req(24'd100, 16'd0, 24'd50);
    queue_req(24'h80_0000, 16'd2, '0);
    queue_req(24'h80_0000, 16'h8000, 24'h10);
    wait_drained();

    // capacity below the head, oversize, wrap with padding, exact fit, clamp at the top
    set_config(24'd1000, 16'd64);
    queue_req(24'd1001, 16'd0, '0);
    queue_req(24'd1000, 16'd0, '0);
    queue_req(24'd10, 16'd0, 24'd500);
    queue_req(24'd936, 16'd0, '0);
    queue_req('0, 16'd0, 24'd1000);
    queue_req(24'd100, 16'd0, 24'd600);
    queue_req(24'd800, 16'd3, 24'd1000);
    queue_req(24'd30, 16'd0, '0);
    queue_req(24'd1, 16'hFFFF, '0);
    queue_req(24'd1, 16'd0, 24'd65);
    wait_drained();

    // smallest ring with the widest padding
    set_config(24'd1, 16'hFFFF);
    queue_req(24'd2, 16'd0, '0);
    queue_req(24'd1, 16'd0, '0);
    queue_req('0, 16'd1, 24'd1);
    queue_req(24'd1, 16'd0, '0);
    queue_req('0, 16'd0, '0);
    wait_drained();

    // random phases over a spread of settings
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 6) begin
        phase_cap[p] = ofs_t'($urandom_range(1, 5000));
        phase_ma[p] = aln_t'($urandom_range(0, 300));
      end
      set_config(phase_cap[p], phase_ma[p]);
      idle_en = (p != 3);
      if (p == 1) hold_req++;
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == PhaseItems / 2) wait_drained();
        r = pick_req(gen_cfg.capacity, gen_head);
        queue_req(r.size, r.align, r.tail);
      end
      wait_drained();
    end

    if (grant_q.size() != 0) $error("tb: %0d grants never arrived", grant_q.size());
    $display("tb: %0d requests checked, %0d granted and %0d refused, over %0d register settings",
             n_req, n_granted, n_refused, NumPhases + 3);
    $display("tb: included random stalls on both sides, a long output hold-off and a drain pause");
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rba_pkg.sv
hw/rtl/rba_pad_serial.sv
hw/rtl/ring_buffer_aligned_allocator.sv
hw/rtl/rba_checker.sv
test/tb.sv
